/* src/mrc_pkg.sv */
`timescale 1ns / 1ps
// mrc_pkg: shared types, status codes and crc helpers for the modbus rtu response checker
// no dependencies

package mrc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_ILLEGAL_FN  = 3'd1;
    localparam logic [2:0] ST_BAD_ADDR    = 3'd2;
    localparam logic [2:0] ST_BAD_VALUE   = 3'd3;
    localparam logic [2:0] ST_DEV_FAIL    = 3'd4;
    localparam logic [2:0] ST_BUSY        = 3'd5;
    localparam logic [2:0] ST_INVALID     = 3'd6;
    localparam logic [2:0] ST_CRC_ERR     = 3'd7;

    localparam logic [7:0] EXC_ILLEGAL_FN = 8'h01;
    localparam logic [7:0] EXC_BAD_ADDR   = 8'h02;
    localparam logic [7:0] EXC_BAD_VALUE  = 8'h03;
    localparam logic [7:0] EXC_DEV_FAIL   = 8'h04;
    localparam logic [7:0] EXC_BUSY       = 8'h06;

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_done;
        logic [2:0] status;
        logic [7:0] slave_address;
        logic [7:0] function_code;
        logic [7:0] byte_count;
    } result_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [2:0] exception_status(input logic [7:0] code);
        logic [2:0] st;
        unique case (code)
            EXC_ILLEGAL_FN: st = ST_ILLEGAL_FN;
            EXC_BAD_ADDR:   st = ST_BAD_ADDR;
            EXC_BAD_VALUE:  st = ST_BAD_VALUE;
            EXC_DEV_FAIL:   st = ST_DEV_FAIL;
            EXC_BUSY:       st = ST_BUSY;
            default:        st = ST_INVALID;
        endcase
        return st;
    endfunction

endpackage

/* src/mrc_front.sv */
`timescale 1ns / 1ps
// mrc_front: byte intake, header capture, crc delay line and result classification
// depends on mrc_pkg

module mrc_front import mrc_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       push,
    input  logic       push_ready,
    output result_t    push_item
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int IDX_W = (POS_W > 8) ? POS_W : 8;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       held0_reg, held1_reg;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       slave_reg, slave_next;
    logic [7:0]       func_reg, func_next;
    logic [7:0]       count_reg, count_next;
    logic [IDX_W-1:0] pay_pos;
    logic             emit;
    logic             accept;
    logic [2:0]       status;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        slave_next = (pos_reg == POS_W'(0)) ? in_byte : slave_reg;
        func_next  = (pos_reg == POS_W'(1)) ? in_byte : func_reg;
        count_next = (pos_reg == POS_W'(2)) ? in_byte : count_reg;
        crc_next   = (pos_reg >= POS_W'(2)) ? crc_fold(crc_reg, held0_reg) : crc_reg;
        pos_next   = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
        pay_pos    = IDX_W'(pos_reg) - IDX_W'(5);
        emit       = (pos_reg >= POS_W'(5)) && (pos_reg < POS_MAX)
                     && (pay_pos < IDX_W'(count_next));
        if (pos_reg < POS_W'(4)) begin
            status = ST_INVALID;
        end else if (pos_reg == POS_W'(4)) begin
            status = exception_status(count_next);
        end else begin
            status = ({in_byte, held1_reg} == crc_next) ? ST_OK : ST_CRC_ERR;
        end
    end

    always_comb begin
        push_item.data_valid    = emit;
        push_item.payload_byte  = emit ? held0_reg : 8'h00;
        push_item.payload_index = emit ? pay_pos[7:0] : 8'h00;
        push_item.frame_done    = in_last;
        push_item.status        = in_last ? status : ST_OK;
        push_item.slave_address = slave_next;
        push_item.function_code = func_next;
        push_item.byte_count    = count_next;
    end

    assign push = accept && (emit || in_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            held0_reg <= '0;
            held1_reg <= '0;
            crc_reg   <= CRC_INIT;
            slave_reg <= '0;
            func_reg  <= '0;
            count_reg <= '0;
        end else if (accept) begin
            if (in_last) begin
                pos_reg   <= '0;
                held0_reg <= '0;
                held1_reg <= '0;
                crc_reg   <= CRC_INIT;
                slave_reg <= '0;
                func_reg  <= '0;
                count_reg <= '0;
            end else begin
                pos_reg   <= pos_next;
                held0_reg <= held1_reg;
                held1_reg <= in_byte;
                crc_reg   <= crc_next;
                slave_reg <= slave_next;
                func_reg  <= func_next;
                count_reg <= count_next;
            end
        end
    end

    a_pos_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_last) |=> (pos_reg == '0 && crc_reg == CRC_INIT))
        else $error("frame state not cleared after last byte");

    a_pos_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_MAX)
        else $error("frame position beyond maximum");

    a_no_emit_early: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_item.data_valid) |-> (pos_reg >= POS_W'(5)))
        else $error("payload item emitted inside header or crc window");

endmodule

/* src/mrc_fifo.sv */
`timescale 1ns / 1ps
// mrc_fifo: short result queue between the classifier and the output channel
// depends on mrc_pkg

module mrc_fifo import mrc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    output logic    push_ready,
    input  result_t push_item,
    output logic    pop_valid,
    input  logic    pop_ready,
    output result_t pop_item
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    result_t          mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             pop;

    assign push_ready = (cnt_reg != CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg < CNT_W'(FIFO_DEPTH)))
        else $error("push into full result queue");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("queue count lost a push");

endmodule

/* src/modbus_rtu_response_checker.sv */
`timescale 1ns / 1ps
// modbus_rtu_response_checker: top level, streaming crc-16 check of modbus rtu responses
// depends on mrc_pkg, mrc_front, mrc_fifo
//
// channel  dir  tdata                         tuser       tlast
// s_       in   [7:0] rx_byte                 -           end_of_frame
// m_       out  payload/index/status/header   data_valid  frame_done
//
// one byte accepted per cycle; crc fold and compare settle in the intake cycle
// results are written into a two-entry queue that drives m_ from its registered entries
// intake stalls only while the queue is full; m_ stalls fill the queue first
// synchronous active-low reset clears the frame state and empties the queue

module modbus_rtu_response_checker import mrc_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [18:16] status, [26:19] slave_address,
    // [34:27] function_code, [42:35] byte_count, [47:43] zero
    output logic [47:0] m_tdata,
    output logic        m_tuser,   // [0] data_valid
    output logic        m_tlast
);

    logic    push;
    logic    push_ready;
    result_t push_item;
    result_t pop_item;

    mrc_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    mrc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (m_tvalid),
        .pop_ready  (m_tready),
        .pop_item   (pop_item)
    );

    assign m_tdata = {5'b00000,
                      pop_item.byte_count,
                      pop_item.function_code,
                      pop_item.slave_address,
                      pop_item.status,
                      pop_item.payload_index,
                      pop_item.payload_byte};
    assign m_tuser = pop_item.data_valid;
    assign m_tlast = pop_item.frame_done;

endmodule

/* tb/tb_modbus_rtu_response_checker.sv */
`timescale 1ns / 1ps
// tb_modbus_rtu_response_checker: self-checking bench for the modbus rtu response checker
// drives directed and random response frames, predicts payload/status items, compares at m_
// depends on mrc_pkg and modbus_rtu_response_checker

module tb_modbus_rtu_response_checker import mrc_pkg::*; ();

    localparam int MAX_FRAME = 256;
    localparam int N_DIR = 27;
    localparam int ITEM_TARGET = 950;
    localparam int CYCLE_LIMIT = 600000;

    typedef enum logic [1:0] {ROW_DATA, ROW_CRC_LO, ROW_CRC_HI} row_kind_t;

    typedef struct {
        logic [7:0] rx;
        bit         last;
        row_kind_t  kind;
        bit         typed;
        result_t    want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // predictor state
    logic [7:0]  rsp_held [2];
    logic [15:0] rsp_crc;
    int          rsp_pos;
    logic [7:0]  hdr_slave;
    logic [7:0]  hdr_func;
    logic [7:0]  hdr_count;

    result_t     pending_results [$];
    logic [15:0] tx_crc;
    logic [15:0] crc_hold;
    bit          calm;
    int          ready_hold;
    int          mismatches;
    int          items_sent;
    int          frames_sent;
    int          results_checked;
    int          payload_seen;
    int          cycle_cnt;
    logic [7:0]  status_seen;
    stim_row_t   dir_rows [N_DIR];

    modbus_rtu_response_checker #(.MAX_FRAME_BYTES(MAX_FRAME)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        bit          lsb;
        c = acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            lsb = c[0];
            c = {1'b0, c[15:1]};
            if (lsb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic [2:0] exception_to_status(input logic [7:0] code);
        case (code)
            EXC_ILLEGAL_FN: return ST_ILLEGAL_FN;
            EXC_BAD_ADDR:   return ST_BAD_ADDR;
            EXC_BAD_VALUE:  return ST_BAD_VALUE;
            EXC_DEV_FAIL:   return ST_DEV_FAIL;
            EXC_BUSY:       return ST_BUSY;
            default:        return ST_INVALID;
        endcase
    endfunction

    function automatic void clear_frame_state();
        rsp_held[0] = 8'h00;
        rsp_held[1] = 8'h00;
        rsp_crc = CRC_INIT;
        rsp_pos = 0;
        hdr_slave = 8'h00;
        hdr_func = 8'h00;
        hdr_count = 8'h00;
    endfunction

    // one received byte through the frame checker; has_res tells if an item comes out
    function automatic void predict_byte(input logic [7:0] b, input bit last,
                                         output bit has_res, output result_t r);
        int          p;
        logic [7:0]  conf;
        logic [7:0]  prev;
        logic [15:0] rx_crc;
        p = rsp_pos;
        r = '0;
        prev = rsp_held[1];
        if (p == 0) begin
            hdr_slave = b;
        end else if (p == 1) begin
            hdr_func = b;
        end else if (p == 2) begin
            hdr_count = b;
        end
        if (p >= 2) begin
            conf = rsp_held[0];
            rsp_crc = crc16_update(rsp_crc, conf);
            if (p >= 5 && p < MAX_FRAME && (p - 5) < int'(hdr_count)) begin
                r.data_valid = 1'b1;
                r.payload_byte = conf;
                r.payload_index = 8'(p - 5);
            end
        end
        rsp_held[0] = rsp_held[1];
        rsp_held[1] = b;
        if (last) begin
            r.frame_done = 1'b1;
            if (p < 4) begin
                r.status = ST_INVALID;
            end else if (p == 4) begin
                r.status = exception_to_status(hdr_count);
            end else begin
                rx_crc = {b, prev};
                r.status = (rx_crc == rsp_crc) ? ST_OK : ST_CRC_ERR;
            end
        end
        r.slave_address = hdr_slave;
        r.function_code = hdr_func;
        r.byte_count = hdr_count;
        has_res = r.data_valid || last;
        if (last) begin
            clear_frame_state();
        end else if (p < MAX_FRAME) begin
            rsp_pos = p + 1;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    function automatic stim_row_t dbyte(input logic [7:0] b);
        stim_row_t row;
        row = '{rx: b, last: 1'b0, kind: ROW_DATA, typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic stim_row_t crc_row(input row_kind_t kind);
        stim_row_t row;
        row = '{rx: 8'h00, last: (kind == ROW_CRC_HI), kind: kind, typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic stim_row_t last_pred(input logic [7:0] b);
        stim_row_t row;
        row = '{rx: b, last: 1'b1, kind: ROW_DATA, typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic stim_row_t last_typed(input logic [7:0] b, input logic [2:0] st,
                                             input logic [7:0] sa, input logic [7:0] fc,
                                             input logic [7:0] bc);
        stim_row_t row;
        row = '{rx: b, last: 1'b1, kind: ROW_DATA, typed: 1'b1, want: '0};
        row.want.frame_done = 1'b1;
        row.want.status = st;
        row.want.slave_address = sa;
        row.want.function_code = fc;
        row.want.byte_count = bc;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch %s: got 0x%0h want 0x%0h (item %0d)",
                 $realtime, what, got, want, results_checked);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                             input result_t typed_res);
        int      gap;
        bit      has_res;
        result_t r;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_byte(b, last, has_res, r);
        if (typed) begin
            pending_results.push_back(typed_res);
        end else if (has_res) begin
            pending_results.push_back(r);
        end
        items_sent++;
        if (last) begin
            frames_sent++;
            tx_crc = CRC_INIT;
        end else begin
            tx_crc = crc16_update(tx_crc, b);
        end
    endtask

    task automatic send_crc(input bit corrupt);
        crc_hold = tx_crc;
        if (corrupt) begin
            crc_hold = crc_hold ^ 16'($urandom_range(1, 65535));
        end
        send_byte(crc_hold[7:0], 1'b0, 1'b0, '0);
        send_byte(crc_hold[15:8], 1'b1, 1'b0, '0);
    endtask

    task automatic send_reply(input logic [7:0] count, input int plen, input bit corrupt);
        send_byte(8'($urandom), 1'b0, 1'b0, '0);
        send_byte(8'($urandom), 1'b0, 1'b0, '0);
        send_byte(count, 1'b0, 1'b0, '0);
        for (int i = 0; i < plen; i++) begin
            send_byte(8'($urandom), 1'b0, 1'b0, '0);
        end
        send_crc(corrupt);
    endtask

    task automatic send_random_frame();
        int          kind;
        int          n;
        logic [7:0]  count;
        logic [7:0]  code;
        kind = $urandom_range(0, 99);
        calm = ($urandom_range(0, 99) < 20);
        if (kind < 55) begin
            count = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 10))
                                                 : 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 75 && count <= 16) begin
                n = int'(count);
            end else begin
                n = $urandom_range(0, 16);
            end
            send_reply(count, n, $urandom_range(0, 99) < 15);
        end else if (kind < 70) begin
            case ($urandom_range(0, 6))
                0:       code = EXC_ILLEGAL_FN;
                1:       code = EXC_BAD_ADDR;
                2:       code = EXC_BAD_VALUE;
                3:       code = EXC_DEV_FAIL;
                4:       code = EXC_BUSY;
                default: code = 8'($urandom);
            endcase
            send_byte(8'($urandom), 1'b0, 1'b0, '0);
            send_byte(8'($urandom) | 8'h80, 1'b0, 1'b0, '0);
            send_byte(code, 1'b0, 1'b0, '0);
            send_crc($urandom_range(0, 99) < 15);
        end else begin
            // short frames and raw noise
            n = (kind < 82) ? $urandom_range(1, 4) : $urandom_range(5, 24);
            for (int i = 0; i < n; i++) begin
                send_byte(8'($urandom), i == n - 1, 1'b0, '0);
            end
        end
    endtask

    // result side: random backpressure, checking and the watchdog
    always @(posedge aclk) begin : result_side
        result_t got;
        result_t want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items outstanding",
                     cycle_cnt, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.data_valid = m_tuser;
            got.payload_byte = m_tdata[7:0];
            got.payload_index = m_tdata[15:8];
            got.status = m_tdata[18:16];
            got.slave_address = m_tdata[26:19];
            got.function_code = m_tdata[34:27];
            got.byte_count = m_tdata[42:35];
            got.frame_done = m_tlast;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", int'(m_tdata[31:0]), 0);
            end else begin
                want = pending_results.pop_front();
                if (got.data_valid !== want.data_valid)
                    report_mismatch("data_valid", int'(got.data_valid),
                                    int'(want.data_valid));
                if (got.payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", int'(got.payload_byte),
                                    int'(want.payload_byte));
                if (got.payload_index !== want.payload_index)
                    report_mismatch("payload_index", int'(got.payload_index),
                                    int'(want.payload_index));
                if (got.frame_done !== want.frame_done)
                    report_mismatch("frame_done", int'(got.frame_done),
                                    int'(want.frame_done));
                if (got.status !== want.status)
                    report_mismatch("status", int'(got.status), int'(want.status));
                if (got.slave_address !== want.slave_address)
                    report_mismatch("slave_address", int'(got.slave_address),
                                    int'(want.slave_address));
                if (got.function_code !== want.function_code)
                    report_mismatch("function_code", int'(got.function_code),
                                    int'(want.function_code));
                if (got.byte_count !== want.byte_count)
                    report_mismatch("byte_count", int'(got.byte_count),
                                    int'(want.byte_count));
                if (want.frame_done) begin
                    status_seen[want.status] = 1'b1;
                end
                if (want.data_valid) begin
                    payload_seen++;
                end
            end
            results_checked++;
        end
        if (ready_hold > 0) begin
            ready_hold--;
        end else if ($urandom_range(0, 99) < 70) begin
            m_tready <= 1'b1;
            ready_hold = $urandom_range(0, 40);
        end else begin
            m_tready <= 1'b0;
            ready_hold = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                      : $urandom_range(4, 30);
        end
    end

    initial begin : stimulus
        logic [7:0] b;
        int         long_cnt;
        mismatches = 0;
        items_sent = 0;
        frames_sent = 0;
        results_checked = 0;
        payload_seen = 0;
        cycle_cnt = 0;
        ready_hold = 0;
        status_seen = '0;
        calm = 1'b0;
        long_cnt = 0;
        tx_crc = CRC_INIT;
        crc_hold = CRC_INIT;
        clear_frame_state();

        dir_rows = '{
            // all-ones short frame of four bytes
            dbyte(8'hFF), dbyte(8'hFF), dbyte(8'hFF),
            last_typed(8'hFF, ST_INVALID, 8'hFF, 8'hFF, 8'hFF),
            // exception frame, busy
            dbyte(8'h11), dbyte(8'h83), dbyte(EXC_BUSY), dbyte(8'h5A),
            last_typed(8'hA5, ST_BUSY, 8'h11, 8'h83, EXC_BUSY),
            // exception frame, unknown code, zero address
            dbyte(8'h00), dbyte(8'h84), dbyte(8'hFF), dbyte(8'h00),
            last_typed(8'hFF, ST_INVALID, 8'h00, 8'h84, 8'hFF),
            // good reply with two payload bytes
            dbyte(8'h01), dbyte(8'h03), dbyte(8'h02), dbyte(8'hAA), dbyte(8'h55),
            crc_row(ROW_CRC_LO), crc_row(ROW_CRC_HI),
            // byte count beyond payload, crc wrong
            dbyte(8'hF7), dbyte(8'h03), dbyte(8'hFF), dbyte(8'h80), dbyte(8'h7F),
            last_pred(8'h7F)
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CRC_LO: begin
                    crc_hold = tx_crc;
                    b = crc_hold[7:0];
                end
                ROW_CRC_HI: b = crc_hold[15:8];
                default:    b = dir_rows[i].rx;
            endcase
            send_byte(b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
        end

        while (items_sent < ITEM_TARGET) begin
            if ((long_cnt == 0 && items_sent >= 200) || (long_cnt == 1 && items_sent >= 600)) begin
                // long frames, some of which run past the position limit
                calm = 1'b0;
                send_reply((long_cnt == 0) ? 8'hFF : 8'($urandom_range(240, 255)),
                           $urandom_range(248, 262), long_cnt == 1);
                long_cnt++;
            end else begin
                send_random_frame();
            end
        end
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("sent %0d frames in %0d bytes, %0d long; checked %0d items, %0d payload",
                 frames_sent, items_sent, long_cnt, results_checked, payload_seen);
        $display("frame status codes seen (bit per code): %b, mismatches: %0d",
                 status_seen, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
